>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define HTBD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define HTBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/htbd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree build and decode package
// Sizes, codes, node record and control types shared by the design.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int SYMBOLS     = 256;
	localparam int SYM_BITS    = 8;
	localparam int COUNT_BITS  = 24;
	localparam int NODES       = 2 * SYMBOLS - 1;
	localparam int NODE_BITS   = $clog2(NODES);
	localparam int LEAF_BITS   = SYM_BITS + 1;
	localparam int WEIGHT_BITS = COUNT_BITS + SYM_BITS + 1;
	localparam int MAX_BITS    = 8;

	localparam logic [LEAF_BITS-1:0] SYM_END = LEAF_BITS'(SYMBOLS);

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_SYM = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_BUILD  = 2'd2,
		OP_DECODE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FEW     = 2'd1,
		ST_NO_TREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACK,
		S_LSCAN,
		S_LCHK,
		S_MSCAN,
		S_RDA,
		S_WRA,
		S_RDB,
		S_WRB,
		S_WRI,
		S_DRD,
		S_DCHK,
		S_DSYM,
		S_DEND
	} state_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [NODE_BITS-1:0]   left;
		logic [NODE_BITS-1:0]   right;
		logic                   free;
		logic [SYM_BITS-1:0]    sym;
	} node_t;

	typedef struct packed {
		logic clr;
		logic en;
	} min_ctl_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]   a;
		logic [NODE_BITS-1:0]   b;
		logic [WEIGHT_BITS-1:0] wa;
		logic [WEIGHT_BITS-1:0] wb;
	} min_res_t;

endpackage

>>> design/htbd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface htbd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  symbol;
	logic [23:0] count;
	logic [7:0]  code_byte;
	logic [3:0]  bit_count;

	modport source (output valid, op, symbol, count, code_byte, bit_count, input ready);
	modport sink (input valid, op, symbol, count, code_byte, bit_count, output ready);
endinterface

// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface htbd_rsp_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [1:0] status;
	logic [7:0] decoded;
	logic       last;

	modport source (output valid, kind, status, decoded, last, input ready);
	modport sink (input valid, kind, status, decoded, last, output ready);
endinterface

>>> design/huffman_tree_build_and_decode.sv
// ----------------------------------------------------------------------------
// Huffman tree build and decode
// Loads symbol counts, builds a Huffman tree in node RAM, decodes code bytes.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                                       Words per command
// req      in   op, symbol, count, code_byte, bit_count      1
// rsp      out  kind, status, decoded, last                  1 to 8
//
// One command at a time. Decode walks the tree with a dependent child read
// of the node RAM per code bit and emits each symbol it reaches. Build scans
// the counts, then per merge scans the node RAM over nodes below i.
// Reset clears control and count valid bits at once; no clearing pass.
// A stalled response holds the block in its emit state.
// ----------------------------------------------------------------------------
module huffman_tree_build_and_decode import htbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	htbd_req_if.sink   req,
	htbd_rsp_if.source rsp
);

	state_t state_q, state_d;

	// memories
	logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
	logic                  cnt_vld_q [SYMBOLS];
	node_t                 node_mem [NODES];

	logic [COUNT_BITS-1:0] cnt_s1;
	logic                  cnt_vld_s1;
	logic                  lv_s1;
	logic [SYM_BITS-1:0]   sym_s1;
	node_t                 node_rd_q;

	// control and datapath
	logic [LEAF_BITS-1:0]  scan_q;
	logic [LEAF_BITS-1:0]  n_q;
	logic [LEAF_BITS-1:0]  leaf_cnt_q;
	logic [NODE_BITS-1:0]  i_q, j_q, j_s1, cur_q;
	logic                  mv_s1;
	logic                  tree_q;
	status_t               st_q;
	logic [7:0]            code_q;
	logic [3:0]            nb_q, b_q;
	logic                  pend_q;
	logic [SYM_BITS-1:0]   pend_sym_q;

	logic                  ovld_q, okind_q, olast_q;
	logic [1:0]            ostat_q;
	logic [SYM_BITS-1:0]   odec_q;

	logic                  accept, slot_free, leaf_hit;
	logic                  node_re, node_we, cnt_re;
	logic [NODE_BITS-1:0]  node_raddr, node_waddr, child, root;
	node_t                 node_wdata;
	logic                  emit, e_kind, e_last;
	logic [1:0]            e_stat;
	logic [SYM_BITS-1:0]   e_dec;
	logic                  code_bit, bits_done;
	logic [3:0]            nb_in;
	min_ctl_t              min_ctl;
	min_res_t              min_res;

	assign accept    = req.valid && req.ready;
	assign slot_free = !ovld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign root      = NODE_BITS'({leaf_cnt_q, 1'b0} - (LEAF_BITS + 1)'(2));
	assign code_bit  = code_q[3'd7 - b_q[2:0]];
	assign child     = code_bit ? node_rd_q.right : node_rd_q.left;
	assign leaf_hit  = ({1'b0, child} < {1'b0, leaf_cnt_q});
	assign bits_done = ((b_q + 4'd1) == nb_q);
	assign nb_in     = (req.bit_count > 4'(MAX_BITS)) ? 4'(MAX_BITS) : req.bit_count;

	htbd_min2 u_min2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (min_ctl),
		.idx    (j_s1),
		.weight (node_rd_q.weight),
		.res    (min_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory strobes, emit request
	always_comb begin
		state_d    = state_q;
		node_re    = 1'b0;
		node_raddr = cur_q;
		node_we    = 1'b0;
		node_waddr = i_q;
		node_wdata = node_rd_q;
		cnt_re     = 1'b0;
		emit       = 1'b0;
		e_kind     = KIND_ACK;
		e_stat     = ST_OK;
		e_dec      = '0;
		e_last     = 1'b1;
		min_ctl    = '{clr: 1'b0, en: mv_s1 && node_rd_q.free};

		// leaf write from the count scan
		if (lv_s1 && cnt_vld_s1 && cnt_s1 != '0) begin
			node_we    = 1'b1;
			node_waddr = NODE_BITS'(n_q);
			node_wdata = '{weight: WEIGHT_BITS'(cnt_s1), left: '0, right: '0,
				free: 1'b1, sym: sym_s1};
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(req.op))
						OP_CLEAR, OP_LOAD: state_d = S_ACK;
						OP_BUILD:          state_d = S_LSCAN;
						OP_DECODE: begin
							if (!tree_q) state_d = S_ACK;
							else if (nb_in == 4'd0) state_d = S_DEND;
							else state_d = S_DRD;
						end
						default: state_d = S_ACK;
					endcase
				end
			end
			S_ACK: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_stat  = st_q;
					state_d = S_IDLE;
				end
			end
			S_LSCAN: begin
				cnt_re = (scan_q < SYM_END);
				if (scan_q == SYM_END) state_d = S_LCHK;
			end
			S_LCHK: begin
				min_ctl.clr = 1'b1;
				state_d     = (n_q < LEAF_BITS'(2)) ? S_ACK : S_MSCAN;
			end
			S_MSCAN: begin
				node_re    = (j_q < i_q);
				node_raddr = j_q;
				if (j_q == i_q) state_d = S_RDA;
			end
			S_RDA: begin
				node_re    = 1'b1;
				node_raddr = min_res.a;
				state_d    = S_WRA;
			end
			S_WRA: begin
				node_we         = 1'b1;
				node_waddr      = min_res.a;
				node_wdata      = node_rd_q;
				node_wdata.free = 1'b0;
				state_d         = S_RDB;
			end
			S_RDB: begin
				node_re    = 1'b1;
				node_raddr = min_res.b;
				state_d    = S_WRB;
			end
			S_WRB: begin
				node_we         = 1'b1;
				node_waddr      = min_res.b;
				node_wdata      = node_rd_q;
				node_wdata.free = 1'b0;
				state_d         = S_WRI;
			end
			S_WRI: begin
				node_we     = 1'b1;
				node_waddr  = i_q;
				node_wdata  = '{weight: min_res.wa + min_res.wb, left: min_res.a,
					right: min_res.b, free: 1'b1, sym: '0};
				min_ctl.clr = 1'b1;
				state_d     = (i_q == root) ? S_ACK : S_MSCAN;
			end
			S_DRD: begin
				node_re    = 1'b1;
				node_raddr = cur_q;
				state_d    = S_DCHK;
			end
			S_DCHK: begin
				if (leaf_hit) begin
					node_re    = 1'b1;
					node_raddr = child;
					state_d    = S_DSYM;
				end else begin
					state_d = bits_done ? S_DEND : S_DRD;
				end
			end
			S_DSYM: begin
				if (!pend_q || slot_free) begin
					emit    = pend_q;
					e_kind  = KIND_SYM;
					e_dec   = pend_sym_q;
					e_last  = 1'b0;
					state_d = bits_done ? S_DEND : S_DRD;
				end
			end
			S_DEND: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = pend_q ? KIND_SYM : KIND_ACK;
					e_dec   = pend_q ? pend_sym_q : '0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// count store and its valid bits
	always_ff @(posedge clk) begin
		if (accept && op_t'(req.op) == OP_LOAD) cnt_mem[req.symbol] <= req.count;
		if (cnt_re) cnt_s1 <= cnt_mem[scan_q[SYM_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SYMBOLS; k++) cnt_vld_q[k] <= 1'b0;
		end else if (accept && op_t'(req.op) == OP_CLEAR) begin
			for (int k = 0; k < SYMBOLS; k++) cnt_vld_q[k] <= 1'b0;
		end else if (accept && op_t'(req.op) == OP_LOAD) begin
			cnt_vld_q[req.symbol] <= 1'b1;
		end
	end

	// node RAM
	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_waddr] <= node_wdata;
		if (node_re) node_rd_q <= node_mem[node_raddr];
	end

	// scan pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_s1 <= 1'b0;
			mv_s1 <= 1'b0;
		end else begin
			lv_s1 <= cnt_re;
			mv_s1 <= (state_q == S_MSCAN) && (j_q < i_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_re) begin
			cnt_vld_s1 <= cnt_vld_q[scan_q[SYM_BITS-1:0]];
			sym_s1     <= scan_q[SYM_BITS-1:0];
		end
		j_s1 <= j_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_q     <= 1'b0;
			leaf_cnt_q <= '0;
			cur_q      <= '0;
			st_q       <= ST_OK;
			pend_q     <= 1'b0;
			scan_q     <= '0;
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			b_q        <= '0;
			nb_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q   <= ST_OK;
						scan_q <= '0;
						n_q    <= '0;
						b_q    <= '0;
						nb_q   <= nb_in;
						pend_q <= 1'b0;
						if (op_t'(req.op) == OP_CLEAR) tree_q <= 1'b0;
						if (op_t'(req.op) == OP_DECODE && !tree_q) st_q <= ST_NO_TREE;
					end
				end
				S_LSCAN: begin
					if (scan_q != SYM_END) scan_q <= scan_q + LEAF_BITS'(1);
					if (lv_s1 && cnt_vld_s1 && cnt_s1 != '0) n_q <= n_q + LEAF_BITS'(1);
				end
				S_LCHK: begin
					leaf_cnt_q <= n_q;
					i_q        <= NODE_BITS'(n_q);
					j_q        <= '0;
					if (n_q < LEAF_BITS'(2)) begin
						tree_q <= 1'b0;
						cur_q  <= '0;
						st_q   <= ST_FEW;
					end
				end
				S_MSCAN: begin
					if (j_q != i_q) j_q <= j_q + NODE_BITS'(1);
				end
				S_WRI: begin
					i_q <= i_q + NODE_BITS'(1);
					j_q <= '0;
					if (i_q == root) begin
						tree_q <= 1'b1;
						cur_q  <= root;
					end
				end
				S_DCHK: begin
					if (!leaf_hit) begin
						cur_q <= child;
						b_q   <= b_q + 4'd1;
					end
				end
				S_DSYM: begin
					if (!pend_q || slot_free) begin
						pend_q <= 1'b1;
						cur_q  <= root;
						b_q    <= b_q + 4'd1;
					end
				end
				S_DEND: begin
					if (slot_free) pend_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// decode byte and pending symbol
	always_ff @(posedge clk) begin
		if (accept) code_q <= req.code_byte;
		if (state_q == S_DSYM && (!pend_q || slot_free)) pend_sym_q <= node_rd_q.sym;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (emit && slot_free) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			okind_q <= e_kind;
			ostat_q <= e_stat;
			odec_q  <= e_dec;
			olast_q <= e_last;
		end
	end

	assign rsp.valid   = ovld_q;
	assign rsp.kind    = okind_q;
	assign rsp.status  = ostat_q;
	assign rsp.decoded = odec_q;
	assign rsp.last    = olast_q;

endmodule

>>> design/htbd_min2.sv
// ----------------------------------------------------------------------------
// Two-smallest tracker
// Follows the two lightest free nodes seen during a scan; earlier index wins ties.
// ----------------------------------------------------------------------------
module htbd_min2 import htbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  min_ctl_t               ctl,
	input  logic [NODE_BITS-1:0]   idx,
	input  logic [WEIGHT_BITS-1:0] weight,
	output min_res_t               res
);

	logic                   have1_q, have2_q;
	logic [NODE_BITS-1:0]   a_q, b_q;
	logic [WEIGHT_BITS-1:0] wa_q, wb_q;

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (ctl.clr) begin
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (ctl.en) begin
			if (!have1_q || weight < wa_q) begin
				have2_q <= have1_q;
				have1_q <= 1'b1;
			end else if (!have2_q || weight < wb_q) begin
				have2_q <= 1'b1;
			end
		end
	end

	// candidate indexes and weights
	always_ff @(posedge clk) begin
		if (ctl.en && !ctl.clr) begin
			if (!have1_q || weight < wa_q) begin
				b_q  <= a_q;
				wb_q <= wa_q;
				a_q  <= idx;
				wa_q <= weight;
			end else if (!have2_q || weight < wb_q) begin
				b_q  <= idx;
				wb_q <= weight;
			end
		end
	end

	assign res = '{a: a_q, b: b_q, wa: wa_q, wb: wb_q};

endmodule

>>> design/htbd_checker.sv
// ----------------------------------------------------------------------------
// Huffman tree build and decode checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htbd_checker import htbd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       kind,
	input logic [1:0] status,
	input logic [7:0] decoded,
	input logic       last
);

	// hold a stalled word
	`HTBD_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(decoded) && $stable(kind), "stalled response word changed")
	// acknowledge always closes its command
	`HTBD_ASSERT(a_ack_last, clk, arst_n, rsp_valid && kind == KIND_ACK |-> last, "acknowledge without last")
	// decoded symbols carry ok status
	`HTBD_ASSERT(a_sym_ok, clk, arst_n, rsp_valid && kind == KIND_SYM |-> status == ST_OK, "symbol word with error status")
	// only defined status codes
	`HTBD_ASSERT(a_stat_code, clk, arst_n, rsp_valid |-> status == ST_OK || status == ST_FEW || status == ST_NO_TREE, "undefined status code")
	// no word during reset
	`HTBD_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !rsp_valid, "response valid in reset")

endmodule

bind huffman_tree_build_and_decode htbd_checker u_htbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.kind      (rsp.kind),
	.status    (rsp.status),
	.decoded   (rsp.decoded),
	.last      (rsp.last)
);
